### design/mcpa_pkg.sv
// Shared types, constants and coefficient table for the call payoff accumulator.
// Used by mcpa_ctrl, mcpa_datapath and mc_call_payoff_accumulator; no dependencies.
package mcpa_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPOT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIKE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIFT  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOL    = 2'd3;

   localparam logic [31:0] SPOT_RESET   = 32'd6553600;
   localparam logic [31:0] STRIKE_RESET = 32'd6881280;
   localparam logic [31:0] DRIFT_RESET  = 32'd1966;
   localparam logic [30:0] VOL_RESET    = 31'd13107;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam int          X_LIMIT   = 1 << 20;
   localparam logic [2:0]  HORNER_TOP = 3'd7;

   localparam int MUL_WIDTH  = 33;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;

   typedef struct packed {
      logic signed [15:0] normal_sample;
      logic               last_sample;
   } req_payload_type;

   typedef struct packed {
      logic [47:0] payoff_sum;
      logic [31:0] sample_count;
      logic        sum_overflow;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PMUL, ST_XCALC, ST_YMUL, ST_YCALC, ST_UMUL, ST_UCALC,
      ST_HMUL, ST_HADD, ST_SCALE, ST_SMUL, ST_PAY, ST_ACC, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_PMUL, OP_XCALC, OP_YMUL, OP_YCALC, OP_UMUL, OP_UCALC,
      OP_HMUL, OP_HADD, OP_SCALE, OP_SMUL, OP_PAY, OP_ACC, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic horner_last;
      logic item_last;
      logic out_free;
   } dp_status_type;

   // 1/n! in Q30
   function automatic logic [31:0] inv_fact(input logic [2:0] n);
      logic [31:0] c;
      case (n)
         3'd0:    c = 32'd1073741824;
         3'd1:    c = 32'd1073741824;
         3'd2:    c = 32'd536870912;
         3'd3:    c = 32'd178956971;
         3'd4:    c = 32'd44739243;
         3'd5:    c = 32'd8947849;
         3'd6:    c = 32'd1491308;
         3'd7:    c = 32'd213044;
         default: c = 32'd0;
      endcase
      return c;
   endfunction

endpackage

### design/mcpa_ctrl.sv
// Sequencer for the payoff datapath: walks one sample through the shared multiplier.
// Depends on mcpa_pkg.
module mcpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mcpa_pkg::dp_status_type status,
   output mcpa_pkg::dp_cmd_type    cmd
);
   import mcpa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            cmd.op = OP_PMUL;  state_in = ST_XCALC;
         end
         ST_XCALC: begin
            cmd.op = OP_XCALC; state_in = ST_YMUL;
         end
         ST_YMUL: begin
            cmd.op = OP_YMUL;  state_in = ST_YCALC;
         end
         ST_YCALC: begin
            cmd.op = OP_YCALC; state_in = ST_UMUL;
         end
         ST_UMUL: begin
            cmd.op = OP_UMUL;  state_in = ST_UCALC;
         end
         ST_UCALC: begin
            cmd.op = OP_UCALC; state_in = ST_HMUL;
         end
         ST_HMUL: begin
            cmd.op = OP_HMUL;  state_in = ST_HADD;
         end
         ST_HADD: begin
            cmd.op   = OP_HADD;
            state_in = status.horner_last ? ST_SCALE : ST_HMUL;
         end
         ST_SCALE: begin
            cmd.op = OP_SCALE; state_in = ST_SMUL;
         end
         ST_SMUL: begin
            cmd.op = OP_SMUL;  state_in = ST_PAY;
         end
         ST_PAY: begin
            cmd.op = OP_PAY;   state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = status.item_last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### design/mcpa_datapath.sv
// Datapath: config registers, shared 33x33 multiplier, exp evaluation, accumulator
// and result register. Depends on mcpa_pkg.
module mcpa_datapath #(
   parameter int ACC_WIDTH        = 48,
   parameter int SAMPLE_FRAC_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [mcpa_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mcpa_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  mcpa_pkg::req_payload_type              req_payload,
   input  mcpa_pkg::dp_cmd_type                   cmd,
   output mcpa_pkg::dp_status_type                status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mcpa_pkg::rsp_payload_type              rsp_payload
);
   import mcpa_pkg::*;

   localparam int SUM_WIDTH = (ACC_WIDTH > 48) ? ACC_WIDTH + 1 : 49;
   localparam logic [SUM_WIDTH-1:0] ACC_MAX = (SUM_WIDTH'(1) << ACC_WIDTH) - SUM_WIDTH'(1);

   // configuration
   logic [31:0]        spot_ff, strike_ff;
   logic signed [31:0] drift_ff;
   logic [30:0]        vol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spot_ff   <= SPOT_RESET;
         strike_ff <= STRIKE_RESET;
         drift_ff  <= DRIFT_RESET;
         vol_ff    <= VOL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPOT:   spot_ff   <= csr_wdata;
            CSR_STRIKE: strike_ff <= csr_wdata;
            CSR_DRIFT:  drift_ff  <= csr_wdata;
            CSR_VOL:    vol_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // working registers
   logic signed [15:0]            z_ff;
   logic                          last_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic signed [21:0]            x_ff;
   logic signed [21:0]            y_ff;
   logic [29:0]                   u_ff;
   logic [31:0]                   m_ff;
   logic [2:0]                    cnt_ff;
   logic [31:0]                   e_ff;
   logic [47:0]                   pay_ff;
   logic [ACC_WIDTH-1:0]          acc_ff;
   logic [31:0]                   count_ff;
   logic                          ovf_ff;
   logic                          rsp_valid_ff;
   rsp_payload_type               rsp_ff;

   // shared multiplier operand select
   logic signed [MUL_WIDTH-1:0]  mul_a, mul_b;
   logic signed [PROD_WIDTH-1:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_PMUL: begin
            mul_a = MUL_WIDTH'({1'b0, vol_ff});
            mul_b = MUL_WIDTH'(z_ff);
         end
         OP_YMUL: begin
            mul_a = MUL_WIDTH'(x_ff);
            mul_b = MUL_WIDTH'({1'b0, LOG2E_Q30});
         end
         OP_UMUL: begin
            mul_a = MUL_WIDTH'({1'b0, y_ff[15:0]});
            mul_b = MUL_WIDTH'({1'b0, LN2_Q30});
         end
         OP_HMUL: begin
            mul_a = MUL_WIDTH'({1'b0, m_ff});
            mul_b = MUL_WIDTH'({1'b0, u_ff});
         end
         OP_SMUL: begin
            mul_a = MUL_WIDTH'({1'b0, spot_ff});
            mul_b = MUL_WIDTH'({1'b0, e_ff});
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // exponent: drift + rounded vol product, clamped to +/-16.0
   logic signed [PROD_WIDTH-1:0] x_wide;
   logic signed [21:0]           x_clamped;
   always_comb begin
      x_wide = ((prod_ff + PROD_WIDTH'(1 << (SAMPLE_FRAC_BITS - 1))) >>> SAMPLE_FRAC_BITS)
               + PROD_WIDTH'(drift_ff);
      if (x_wide > PROD_WIDTH'(X_LIMIT))       x_clamped = 22'(X_LIMIT);
      else if (x_wide < -PROD_WIDTH'(X_LIMIT)) x_clamped = -22'(X_LIMIT);
      else                                     x_clamped = x_wide[21:0];
   end

   logic signed [PROD_WIDTH-1:0] y_wide;
   assign y_wide = (prod_ff + PROD_WIDTH'(64'd1 << 29)) >>> 30;

   // scale mantissa by 2^k
   logic signed [5:0] k;
   logic [5:0]        sh;
   logic [39:0]       rnd_sum;
   logic [33:0]       up_val;
   logic [31:0]       e_next;
   always_comb begin
      k       = y_ff[21:16];
      sh      = 6'(6'sd14 - k);
      up_val  = '0;
      rnd_sum = '0;
      if (k >= 6'sd16) begin
         e_next = 32'hFFFF_FFFF;
      end else if (k >= 6'sd14) begin
         up_val = 34'(m_ff) << k[0];
         e_next = (up_val > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : up_val[31:0];
      end else begin
         rnd_sum = (40'(m_ff) + (40'd1 << (sh - 6'd1))) >> sh;
         e_next  = rnd_sum[31:0];
      end
   end

   logic [47:0] st;
   logic [63:0] st_wide;
   assign st_wide = prod_ff[63:0] + 64'h8000;
   assign st      = st_wide[63:16];

   logic [SUM_WIDTH-1:0] sum;
   logic [SUM_WIDTH-1:0] acc_ext;
   assign sum     = SUM_WIDTH'(acc_ff) + SUM_WIDTH'(pay_ff);
   assign acc_ext = SUM_WIDTH'(acc_ff);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            z_ff    <= req_payload.normal_sample;
            last_ff <= req_payload.last_sample;
         end
         OP_PMUL, OP_YMUL, OP_UMUL, OP_HMUL, OP_SMUL: prod_ff <= mul_p;
         OP_XCALC: x_ff <= x_clamped;
         OP_YCALC: y_ff <= y_wide[21:0];
         OP_UCALC: begin
            u_ff   <= prod_ff[45:16];
            m_ff   <= inv_fact(HORNER_TOP);
            cnt_ff <= HORNER_TOP - 3'd1;
         end
         OP_HADD: begin
            m_ff   <= inv_fact(cnt_ff) + prod_ff[61:30];
            cnt_ff <= cnt_ff - 3'd1;
         end
         OP_SCALE: e_ff <= e_next;
         OP_PAY:   pay_ff <= (st > 48'(strike_ff)) ? st - 48'(strike_ff) : 48'd0;
         default: ;
      endcase
   end

   // accumulator state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_ACC: begin
               if (sum > ACC_MAX) begin
                  acc_ff <= ACC_MAX[ACC_WIDTH-1:0];
                  ovf_ff <= 1'b1;
               end else begin
                  acc_ff <= sum[ACC_WIDTH-1:0];
               end
               if (count_ff != 32'hFFFF_FFFF) count_ff <= count_ff + 32'd1;
            end
            OP_EMIT: begin
               rsp_valid_ff <= 1'b1;
               acc_ff       <= '0;
               count_ff     <= '0;
               ovf_ff       <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_ff.payoff_sum   <= acc_ext[47:0];
         rsp_ff.sample_count <= count_ff;
         rsp_ff.sum_overflow <= ovf_ff;
      end
   end

   assign status.horner_last = (cnt_ff == 3'd0);
   assign status.item_last   = last_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;

endmodule

### design/mc_call_payoff_accumulator.sv
// Top level of the Monte Carlo European call payoff accumulator.
// Depends on mcpa_pkg, mcpa_ctrl and mcpa_datapath.
//
//   channel   ports                          direction  carries
//   req       req_valid/req_ready/req_payload  in        one normal draw + batch end
//   rsp       rsp_valid/rsp_ready/rsp_payload  out       payoff sum, count, overflow
//   csr       csr_we/csr_index/csr_wdata       in        spot, strike, drift, vol
//
// Samples are taken one at a time. Eleven passes through the single
//   33x33 multiplier (vol product, log2 scaling, ln2 scaling, seven Horner
//   steps, spot product) are each followed by a register stage.
// At a batch end, an emit step loads the result register.
// Reset (synchronous) clears the sums, the sequencer and the result valid,
//   and reloads the registers with their defaults.
// A total still waiting on rsp_ready holds the next batch end in its emit
//   step, and no further sample is taken until that total transfers.
module mc_call_payoff_accumulator #(
   parameter int ACC_WIDTH        = 48,
   parameter int SAMPLE_FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mcpa_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mcpa_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_we,
   input  logic [mcpa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mcpa_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import mcpa_pkg::*;

   dp_cmd_type    cmd;     // sequencer -> datapath, one operation per cycle
   dp_status_type status;  // loop end, batch end, result register free

   mcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcpa_datapath #(
      .ACC_WIDTH        (ACC_WIDTH),
      .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### bench/mc_call_payoff_accumulator_tb.sv
// Testbench for mc_call_payoff_accumulator: random and directed batches of normal draws,
// with the expected batch totals worked out in a bit-exact fixed point predictor.
// Depends on mcpa_pkg and the block's RTL.
`timescale 1ns / 100ps

module mc_call_payoff_accumulator_tb;
   import mcpa_pkg::*;

   localparam int ACC_W        = 48;
   localparam int FRAC_Z       = 12;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 60;   // settle time after a drain; over twice what a sample takes
   localparam longint LOG2E_FIX = 64'd1549082005;
   localparam longint LN2_FIX   = 64'd744261118;
   localparam longint EXP_CLAMP = 64'd1 << 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_SPOT;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Register copies held by the predictor
   logic [31:0] spot_q16, strike_q16;
   logic signed [31:0] drift_q16;
   logic [30:0] vol_q16;

   // Batch state held by the predictor
   logic [ACC_W-1:0] batch_sum;
   logic [31:0] batch_count;
   logic batch_ovf;

   req_payload_type pending_draws[$];
   rsp_payload_type expected_totals[$];
   int idle_pct = 16;
   int mismatches = 0;
   int cycle_count = 0;

   longint unsigned taylor_coeff[8] = '{64'd1073741824, 64'd1073741824, 64'd536870912,
      64'd178956971, 64'd44739243, 64'd8947849, 64'd1491308, 64'd213044};

   mc_call_payoff_accumulator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // exp(x), x signed Q.16, result Q16.16 saturated to 32 bits
   function automatic longint unsigned exp_fixed(input longint x);
      longint y, k, f, sh;
      longint unsigned u, m, v;
      if (x > EXP_CLAMP) x = EXP_CLAMP;
      if (x < -EXP_CLAMP) x = -EXP_CLAMP;
      y = (x * LOG2E_FIX + (64'sd1 << 29)) >>> 30;
      k = y >>> 16;
      f = y - k * 65536;
      u = (longint'(f) * LN2_FIX) >> 16;
      m = taylor_coeff[7];
      for (int i = 6; i >= 0; i--) m = taylor_coeff[i] + ((m * u) >> 30);
      if (k >= 16) return 64'hFFFF_FFFF;
      sh = 14 - k;
      if (sh <= 0) v = m << (-sh);
      else if (sh >= 62) v = 0;
      else v = (m + (64'd1 << (sh - 1))) >> sh;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return v;
   endfunction

   // Fold one accepted draw into the batch; queue the total on the batch end
   function automatic void accumulate_payoff(input req_payload_type d);
      longint x, p;
      longint unsigned e, st, pay, room;
      rsp_payload_type t;
      p = longint'(vol_q16) * longint'(d.normal_sample);
      x = longint'(drift_q16) + ((p + (64'sd1 << (FRAC_Z - 1))) >>> FRAC_Z);
      e = exp_fixed(x);
      st = (longint'(spot_q16) * e + 64'd32768) >> 16;
      pay = (st > longint'(strike_q16)) ? st - strike_q16 : 0;
      room = {16'd0, {ACC_W{1'b1}}} - batch_sum;
      if (pay > room) begin
         batch_sum = {ACC_W{1'b1}};
         batch_ovf = 1'b1;
      end else begin
         batch_sum = batch_sum + pay[ACC_W-1:0];
      end
      if (batch_count != 32'hFFFF_FFFF) batch_count++;
      if (d.last_sample) begin
         t.payoff_sum = batch_sum;
         t.sample_count = batch_count;
         t.sum_overflow = batch_ovf;
         expected_totals.push_back(t);
         batch_sum = '0;
         batch_count = '0;
         batch_ovf = 1'b0;
      end
   endfunction

   // Driver: holds each draw until its transfer, then takes the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) accumulate_payoff(req_payload);
         if (!req_valid || req_ready) begin
            if (pending_draws.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_payload <= pending_draws.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each total transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_totals.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected total: %p", rsp_payload);
            end else begin
               rsp_payload_type t;
               t = expected_totals.pop_front();
               if (t.payoff_sum !== rsp_payload.payoff_sum
                   || t.sample_count !== rsp_payload.sample_count
                   || t.sum_overflow !== rsp_payload.sum_overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("total mismatch: sum exp %h got %h, count exp %0d got %0d, ovf exp %b got %b",
                        t.payoff_sum, rsp_payload.payoff_sum, t.sample_count,
                        rsp_payload.sample_count, t.sum_overflow, rsp_payload.sum_overflow);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("mc_call_payoff_accumulator verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SPOT:   spot_q16 = val;
         CSR_STRIKE: strike_q16 = val;
         CSR_DRIFT:  drift_q16 = val;
         CSR_VOL:    vol_q16 = val[30:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_market(input logic [31:0] s, input logic [31:0] k,
                             input logic [31:0] dr, input logic [31:0] vo);
      write_reg(CSR_SPOT, s);
      write_reg(CSR_STRIKE, k);
      write_reg(CSR_DRIFT, dr);
      write_reg(CSR_VOL, vo);
   endtask

   task automatic push_draw(input logic [15:0] z, input logic lst);
      req_payload_type d;
      d.normal_sample = z;
      d.last_sample = lst;
      pending_draws.push_back(d);
   endtask

   // Random batches: mostly plausible draws, some over the full 16-bit range
   task automatic push_batches(input int n);
      int left, len;
      logic [15:0] z;
      left = n;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) z = 16'($urandom);
            else z = 16'($signed($urandom_range(0, 24576)) - 12288);
            push_draw(z, i == len - 1);
         end
         left -= len;
      end
   endtask

   task automatic drain;
      wait (pending_draws.size() == 0 && !req_valid && expected_totals.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      spot_q16 = SPOT_RESET;
      strike_q16 = STRIKE_RESET;
      drift_q16 = DRIFT_RESET;
      vol_q16 = VOL_RESET;
      batch_sum = '0;
      batch_count = '0;
      batch_ovf = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes at the reset settings
      push_draw(16'h8000, 1'b0);
      push_draw(16'h7FFF, 1'b0);
      push_draw(16'h0000, 1'b0);
      push_draw(16'hFFFF, 1'b0);
      push_draw(16'h0001, 1'b1);
      push_draw(16'h1000, 1'b1);
      drain();

      // Large exponent: exp saturates; huge spot and zero strike drive the sum to saturation
      set_market(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_draw(16'h7FFF, 1'b0);
      push_draw(16'h7FFF, 1'b0);
      push_draw(16'h8000, 1'b0);
      push_draw(16'h0000, 1'b1);
      push_draw(16'h8000, 1'b1);
      drain();

      // Small exponent: exp rounds to zero, payoffs vanish
      set_market(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd0);
      push_draw(16'h7FFF, 1'b0);
      push_draw(16'h8000, 1'b1);
      drain();

      // Zero spot, and a strike that no price reaches
      set_market(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd65536);
      push_draw(16'h7FFF, 1'b1);
      drain();

      // Random phases, the fourth one with no idling on either side
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 3)
            0: set_market($urandom_range(32'd65536, 32'd13107200),
                          $urandom_range(32'd65536, 32'd13107200),
                          32'($signed($urandom_range(0, 40000)) - 20000),
                          $urandom_range(0, 40000));
            1: set_market($urandom, $urandom, $urandom_range(0, 2000000) - 1000000,
                          $urandom_range(0, 300000));
            default: set_market($urandom, $urandom, $urandom, $urandom);
         endcase
         idle_pct = (ph == 3) ? 0 : 16;
         push_batches(165);
         drain();
      end

      if (mismatches == 0 && expected_totals.size() == 0)
         $display("mc_call_payoff_accumulator verification clean");
      else
         $display("mc_call_payoff_accumulator verification failed");
      $finish;
   end

endmodule
